// ===== rtl/ngdl_pkg.sv =====
// Package for the n-gram draft token lookup unit.
// Shared types, command codes, register map and limits; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ngdl_pkg;

  localparam int PROMPT_DEPTH_DEF  = 2048;
  localparam int HISTORY_DEPTH_DEF = 2048;
  localparam int MAX_DRAFT         = 16;
  localparam int TOTAL_MAX         = 8191;

  localparam logic [1:0] REQ_LOAD_PROMPT  = 2'd0;
  localparam logic [1:0] REQ_LOAD_HISTORY = 2'd1;
  localparam logic [1:0] REQ_SEARCH       = 2'd2;

  localparam logic REG_TOKEN_BUDGET = 1'b0;
  localparam logic REG_MAX_NGRAM    = 1'b1;

  localparam logic [15:0] BUDGET_RST = 16'd128;
  localparam logic [3:0]  NGRAM_RST  = 4'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_NGRAM,
    ST_WIN,
    ST_RD,
    ST_CMP,
    ST_FIN,
    ST_SINGLE,
    ST_EM_RD,
    ST_EM_CAP
  } ngdl_state_t;

endpackage
`default_nettype wire

// ===== rtl/ngdl_ram.sv =====
// Generic RAM: one write port, two registered read ports.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module ngdl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] ra_addr,
  output logic      [WIDTH-1:0]         ra_data,
  input  wire logic [$clog2(DEPTH)-1:0] rb_addr,
  output logic      [WIDTH-1:0]         rb_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end

endmodule
`default_nettype wire

// ===== rtl/ngram_draft_token_lookup_unit.sv =====
// N-gram draft token lookup unit: top level with sequencer and token stores.
// Depends on ngdl_pkg and ngdl_ram.
//
// channel | dir | handshake             | payload
// in      | in  | in_tvalid/in_tready   | in_tdata (fields), in_tuser (req_type)
// out     | out | out_tvalid/out_tready | out_tdata, out_tuser (flags), out_tlast
// cfg     | in  | APB psel/penable      | token_budget @0x0, max_ngram @0x4
//
// A search compares one token pair at a time on a single comparator, window
// by window, n from max_ngram down to 1, prompt then history; each pair is read
// from the stores, then compared, and each drafted item is read, then captured.
// in_tready is low while a search runs.
// Reset (rst_n, synchronous) clears control state; stores are not cleared.
// A stalled output holds the sequencer before the next result is read.
`timescale 1ns / 1ps
`default_nettype none
module ngram_draft_token_lookup_unit
  import ngdl_pkg::*;
#(
  parameter int PROMPT_DEPTH  = PROMPT_DEPTH_DEF,
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // [10:0] position, [74:11] token, [82:75] batch_index, [91:83] batch_size,
  // [92] any_prefill, [93] prefill_active, [94] decode_idle,
  // [105:95] history_step, [117:106] prompt_len, [122:118] draft_limit
  input  wire logic [127:0] in_tdata,
  input  wire logic [1:0]   in_tuser,   // [1:0] req_type
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [4:0] seq_len, [9:5] draft_index, [73:10] draft_token
  output logic [79:0]       out_tdata,
  output logic [1:0]        out_tuser,  // [0] length_written, [1] token_valid
  output logic              out_tlast,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [2:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  localparam int PAW = $clog2(PROMPT_DEPTH);
  localparam int HAW = $clog2(HISTORY_DEPTH);
  localparam int MAW = (PAW > HAW) ? PAW : HAW;
  localparam int CW  = ((MAW > 11) ? MAW : 11) + 2;

  // config
  logic [15:0] budget_r;
  logic [3:0]  ngram_r;
  logic        cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == REG_MAX_NGRAM) ? {28'd0, ngram_r} : {16'd0, budget_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r <= BUDGET_RST;
      ngram_r  <= NGRAM_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_MAX_NGRAM) begin
        ngram_r <= cfg_pwdata[3:0];
      end else begin
        budget_r <= cfg_pwdata[15:0];
      end
    end
  end

  // input fields
  logic [10:0] f_pos, f_step;
  logic [63:0] f_tok;
  logic [7:0]  f_bidx;
  logic [8:0]  f_bsize;
  logic [11:0] f_plen;
  logic [4:0]  f_lim;
  assign f_pos   = in_tdata[10:0];
  assign f_tok   = in_tdata[74:11];
  assign f_bidx  = in_tdata[82:75];
  assign f_bsize = in_tdata[91:83];
  assign f_step  = in_tdata[105:95];
  assign f_plen  = in_tdata[117:106];
  assign f_lim   = in_tdata[122:118];

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  // state
  ngdl_state_t state_r, state_nxt;
  logic [12:0]   rt_r, rt_nxt;
  logic [7:0]    bidx_r, bidx_nxt;
  logic [8:0]    bsize_r, bsize_nxt;
  logic          anypf_r, anypf_nxt;
  logic [CW-1:0] step_r, step_nxt, plen_r, plen_nxt, i_r, i_nxt, src_r, src_nxt;
  logic [4:0]    lim_r, lim_nxt, d_r, d_nxt, k_r, k_nxt, seq_r, seq_nxt;
  logic [3:0]    n_r, n_nxt, j_r, j_nxt;
  logic          ph_r, ph_nxt, fromp_r, fromp_nxt, lw_r, lw_nxt;
  logic          ov_r, ov_nxt, o_lw_r, o_lw_nxt, o_tv_r, o_tv_nxt, o_last_r, o_last_nxt;
  logic [4:0]    o_seq_r, o_seq_nxt, o_di_r, o_di_nxt;
  logic [63:0]   o_tok_r, o_tok_nxt;

  // stores
  logic [63:0] p_a_data, p_b_data, h_a_data, h_b_data;
  logic [CW-1:0] g_idx, ij_idx, sk_idx;
  logic p_we, h_we;
  assign g_idx  = step_r + CW'(1) - CW'(n_r) + CW'(j_r);
  assign ij_idx = i_r + CW'(j_r);
  assign sk_idx = src_r + CW'(k_r);
  assign p_we = in_acc && (in_tuser == REQ_LOAD_PROMPT)
                && ({{(CW-11){1'b0}}, f_pos} < CW'(PROMPT_DEPTH));
  assign h_we = in_acc && (in_tuser == REQ_LOAD_HISTORY)
                && ({{(CW-11){1'b0}}, f_pos} < CW'(HISTORY_DEPTH));

  ngdl_ram #(.WIDTH(64), .DEPTH(PROMPT_DEPTH)) u_prompt (
    .clk     (clk),
    .we      (p_we),
    .waddr   (PAW'(f_pos)),
    .wdata   (f_tok),
    .ra_addr (ij_idx[PAW-1:0]),
    .ra_data (p_a_data),
    .rb_addr (sk_idx[PAW-1:0]),
    .rb_data (p_b_data)
  );

  ngdl_ram #(.WIDTH(64), .DEPTH(HISTORY_DEPTH)) u_history (
    .clk     (clk),
    .we      (h_we),
    .waddr   (HAW'(f_pos)),
    .wdata   (f_tok),
    .ra_addr (g_idx[HAW-1:0]),
    .ra_data (h_a_data),
    .rb_addr ((state_r == ST_EM_RD) ? sk_idx[HAW-1:0] : ij_idx[HAW-1:0]),
    .rb_data (h_b_data)
  );

  assign in_tready = (state_r == ST_IDLE);

  // budget trim
  logic signed [19:0] ssl_s, thr_s, lim_s, t_s;
  logic skip;
  logic [4:0] lim_trim;
  always_comb begin
    ssl_s = signed'({7'd0, rt_r}) + 20'sd1 + signed'({11'd0, bsize_r})
            - signed'({12'd0, bidx_r});
    thr_s = signed'({4'd0, budget_r});
    lim_s = signed'({15'd0, lim_r});
    t_s   = thr_s - ssl_s;
    skip  = 1'b0;
    lim_trim = lim_r;
    if (!anypf_r) begin
      if ((ssl_s + lim_s > thr_s) && (t_s < lim_s)) begin
        lim_trim = t_s[4:0];
      end
      skip = (ssl_s >= thr_s - 20'sd1);
    end
  end

  // window match helpers
  logic [CW-1:0] s_idx, end_idx, room;
  assign s_idx   = i_r + CW'(n_r);
  assign end_idx = ph_r ? step_r : plen_r;
  assign room    = end_idx - s_idx;

  always_comb begin
    state_nxt = state_r;
    rt_nxt = rt_r; bidx_nxt = bidx_r; bsize_nxt = bsize_r; anypf_nxt = anypf_r;
    step_nxt = step_r; plen_nxt = plen_r; i_nxt = i_r; src_nxt = src_r;
    lim_nxt = lim_r; d_nxt = d_r; k_nxt = k_r; seq_nxt = seq_r;
    n_nxt = n_r; j_nxt = j_r; ph_nxt = ph_r; fromp_nxt = fromp_r; lw_nxt = lw_r;
    ov_nxt = ov_r && !out_tready;
    o_lw_nxt = o_lw_r; o_seq_nxt = o_seq_r; o_di_nxt = o_di_r; o_tok_nxt = o_tok_r;
    o_tv_nxt = o_tv_r; o_last_nxt = o_last_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_tuser == REQ_SEARCH)) begin
          rt_nxt    = (f_bidx == 8'd0) ? 13'd0 : rt_r;
          bidx_nxt  = f_bidx;
          bsize_nxt = f_bsize;
          anypf_nxt = in_tdata[92];
          plen_nxt  = ({{(CW-12){1'b0}}, f_plen} > CW'(PROMPT_DEPTH))
                      ? CW'(PROMPT_DEPTH) : {{(CW-12){1'b0}}, f_plen};
          step_nxt  = ({{(CW-11){1'b0}}, f_step} > CW'(HISTORY_DEPTH - 1))
                      ? CW'(HISTORY_DEPTH - 1) : {{(CW-11){1'b0}}, f_step};
          lim_nxt   = (f_lim > 5'(MAX_DRAFT)) ? 5'(MAX_DRAFT) : f_lim;
          d_nxt     = 5'd0;
          seq_nxt   = 5'd0;
          if (in_tdata[93]) begin
            lw_nxt    = 1'b0;
            state_nxt = ST_SINGLE;
          end else if (in_tdata[94]) begin
            lw_nxt    = 1'b1;
            state_nxt = ST_SINGLE;
          end else begin
            lw_nxt    = 1'b1;
            state_nxt = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        lim_nxt = lim_trim;
        n_nxt   = ngram_r;
        state_nxt = (skip || lim_trim == 5'd0) ? ST_FIN : ST_NGRAM;
      end
      ST_NGRAM: begin
        if (n_r == 4'd0) begin
          state_nxt = ST_FIN;
        end else if (step_r < CW'(n_r)) begin
          n_nxt = n_r - 4'd1;
        end else begin
          ph_nxt = 1'b0;
          i_nxt  = '0;
          state_nxt = ST_WIN;
        end
      end
      ST_WIN: begin
        if (s_idx > end_idx) begin
          i_nxt = '0;
          if (ph_r) begin
            n_nxt = n_r - 4'd1;
            state_nxt = ST_NGRAM;
          end else begin
            ph_nxt = 1'b1;
          end
        end else begin
          j_nxt = 4'd0;
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (h_a_data != (ph_r ? h_b_data : p_a_data)) begin
          i_nxt = i_r + CW'(1);
          state_nxt = ST_WIN;
        end else if (j_r != n_r - 4'd1) begin
          j_nxt = j_r + 4'd1;
          state_nxt = ST_RD;
        end else if (s_idx < end_idx) begin
          fromp_nxt = !ph_r;
          src_nxt   = s_idx;
          d_nxt     = (CW'(lim_r) < room) ? lim_r : room[4:0];
          state_nxt = ST_FIN;
        end else begin
          i_nxt = i_r + CW'(1);
          state_nxt = ST_WIN;
        end
      end
      ST_FIN: begin
        seq_nxt = d_r + 5'd1;
        rt_nxt  = (rt_r + 13'(d_r) + 13'd1 < rt_r) ? 13'(TOTAL_MAX)
                  : rt_r + 13'(d_r) + 13'd1;
        if ({1'b0, rt_r} + 14'(d_r) + 14'd1 > 14'(TOTAL_MAX)) begin
          rt_nxt = 13'(TOTAL_MAX);
        end
        k_nxt = 5'd0;
        state_nxt = (d_r == 5'd0) ? ST_SINGLE : ST_EM_RD;
      end
      ST_SINGLE: begin
        if (!ov_r) begin
          ov_nxt = 1'b1;
          o_lw_nxt = lw_r; o_seq_nxt = seq_r; o_di_nxt = 5'd0; o_tok_nxt = '0;
          o_tv_nxt = 1'b0; o_last_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_EM_RD: begin
        if (!ov_r) begin
          state_nxt = ST_EM_CAP;
        end
      end
      ST_EM_CAP: begin
        ov_nxt = 1'b1;
        o_lw_nxt = 1'b1; o_seq_nxt = seq_r; o_di_nxt = k_r + 5'd1;
        o_tok_nxt = fromp_r ? p_b_data : h_b_data;
        o_tv_nxt = 1'b1;
        o_last_nxt = (k_r + 5'd1 == d_r);
        k_nxt = k_r + 5'd1;
        state_nxt = (k_r + 5'd1 == d_r) ? ST_IDLE : ST_EM_RD;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rt_r    <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rt_r    <= rt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bidx_r <= bidx_nxt; bsize_r <= bsize_nxt; anypf_r <= anypf_nxt;
    step_r <= step_nxt; plen_r <= plen_nxt; i_r <= i_nxt; src_r <= src_nxt;
    lim_r <= lim_nxt; d_r <= d_nxt; k_r <= k_nxt; seq_r <= seq_nxt;
    n_r <= n_nxt; j_r <= j_nxt; ph_r <= ph_nxt; fromp_r <= fromp_nxt; lw_r <= lw_nxt;
    o_lw_r <= o_lw_nxt; o_seq_r <= o_seq_nxt; o_di_r <= o_di_nxt; o_tok_r <= o_tok_nxt;
    o_tv_r <= o_tv_nxt; o_last_r <= o_last_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {6'd0, o_tok_r, o_di_r, o_seq_r};
  assign out_tuser  = {o_tv_r, o_lw_r};
  assign out_tlast  = o_last_r;

endmodule
`default_nettype wire

// ===== rtl/ngdl_checker.sv =====
// Port-level checker for the n-gram draft token lookup unit, with its bind.
// Depends on ngram_draft_token_lookup_unit ports only.
`timescale 1ns / 1ps
`default_nettype none
module ngdl_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [79:0] out_tdata,
  input wire logic [1:0]  out_tuser,
  input wire logic        out_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output item changed while stalled");

  a_notok_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[1] |-> out_tlast && out_tdata[9:5] == 5'd0)
    else $error("result without token must be single and last");

  a_prefill: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[4:0] == 5'd0 && !out_tuser[1])
    else $error("prefill result carries a length or token");

  a_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |->
      out_tdata[9:5] != 5'd0 && out_tdata[9:5] < out_tdata[4:0]
      && (out_tlast == (out_tdata[9:5] + 5'd1 == out_tdata[4:0])))
    else $error("draft slot out of range");

endmodule

bind ngram_draft_token_lookup_unit ngdl_checker u_ngdl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
`default_nettype wire

// ===== tb/tb_ngram_draft_token_lookup_unit.sv =====
// Testbench for ngram_draft_token_lookup_unit: directed table, then random
// loads and searches checked against a behavioral lookup predictor.
// Depends on ngdl_pkg and the RTL of the unit.
`timescale 1ns / 1ps
module tb_ngram_draft_token_lookup_unit;
  import ngdl_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int FILL_LEN = 32;
  localparam int PRESS_AT = 300;
  localparam int QUIET_LO = 1200;
  localparam int QUIET_HI = 2400;

  typedef struct packed {
    logic [1:0]  req;
    logic [10:0] pos;
    logic [63:0] tok;
    logic [7:0]  bidx;
    logic [8:0]  bsize;
    logic        anypf;
    logic        pf;
    logic        idle;
    logic [10:0] step;
    logic [11:0] plen;
    logic [4:0]  lim;
  } cmd_t;

  typedef struct packed {
    logic        lw;
    logic [4:0]  seq;
    logic [4:0]  di;
    logic [63:0] tok;
    logic        tv;
    logic        last;
  } draft_t;

  typedef struct packed {
    cmd_t       c;
    bit         typed;
    logic [4:0] e_seq;
    logic       e_lw;
    int         n_exp;
  } dir_row_t;

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, out_tready = 0;
  logic [127:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic in_tready, out_tvalid, out_tlast, cfg_pready;
  logic [79:0] out_tdata;
  logic [1:0] out_tuser;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;

  ngram_draft_token_lookup_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata), .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [63:0] prompt_mem [PROMPT_DEPTH_DEF];
  logic [63:0] hist_mem [HISTORY_DEPTH_DEF];
  int batch_total;
  int budget_reg;
  int ngram_reg;
  draft_t pending_drafts[$];

  int errs = 0, cyc = 0, n_loads = 0, n_search = 0, n_drafts = 0;

  always @(posedge clk) cyc <= cyc + 1;

  function automatic bit quiet();
    return cyc >= QUIET_LO && cyc < QUIET_HI;
  endfunction

  function automatic void push_draft(logic lw, int seq, int di, logic [63:0] tok,
                                     logic tv, logic last, bit keep);
    draft_t r;
    r.lw = lw; r.seq = 5'(seq); r.di = 5'(di); r.tok = tok; r.tv = tv; r.last = last;
    if (keep) pending_drafts.push_back(r);
  endfunction

  // Budget trim; returns 1 when no search is made.
  function automatic bit budget_skip(cmd_t c, int total, inout int lim);
    int sum, left;
    sum = total + 1;
    left = int'(c.bsize) - int'(c.bidx);
    if (c.anypf) return 0;
    if (sum + lim + left > budget_reg && budget_reg - sum - left < lim)
      lim = budget_reg - sum - left;
    return sum + left >= budget_reg - 1;
  endfunction

  function automatic bit reads_stores(cmd_t c);
    int lim, total;
    lim = 16;
    total = (c.bidx == 0) ? 0 : batch_total;
    if (c.req != REQ_SEARCH || c.pf || c.idle || ngram_reg == 0) return 0;
    return !budget_skip(c, total, lim);
  endfunction

  function automatic void lookup_drafts(cmd_t c, bit keep);
    int plen, step, lim, n, g, i, j, s, e, d, src;
    bit skip, found, from_prompt;
    logic [63:0] v;
    d = 0; src = 0; found = 0; from_prompt = 1;
    if (c.req == REQ_LOAD_PROMPT) begin
      prompt_mem[c.pos] = c.tok;
      return;
    end
    if (c.req == REQ_LOAD_HISTORY) begin
      hist_mem[c.pos] = c.tok;
      return;
    end
    if (c.req != REQ_SEARCH) return;
    if (c.bidx == 0) batch_total = 0;
    if (c.pf) begin
      push_draft(0, 0, 0, '0, 0, 1, keep);
      return;
    end
    if (c.idle) begin
      push_draft(1, 0, 0, '0, 0, 1, keep);
      return;
    end
    plen = (c.plen > PROMPT_DEPTH_DEF) ? PROMPT_DEPTH_DEF : int'(c.plen);
    step = int'(c.step);
    lim = (c.lim > MAX_DRAFT) ? MAX_DRAFT : int'(c.lim);
    skip = budget_skip(c, batch_total, lim);
    for (n = ngram_reg; !skip && !found && n > 0; n--) begin
      g = step + 1 - n;
      if (step < n) continue;
      for (i = 0; !found && i <= plen - n; i++) begin
        for (j = 0; j < n; j++)
          if (hist_mem[g + j] != prompt_mem[i + j]) break;
        if (j == n) begin
          s = i + n; e = s + lim;
          if (e > plen) e = plen;
          if (s < e) begin
            found = 1; from_prompt = 1; src = s; d = e - s;
          end
        end
      end
      for (i = 0; !found && i <= step - n; i++) begin
        for (j = 0; j < n; j++)
          if (hist_mem[g + j] != hist_mem[i + j]) break;
        if (j == n) begin
          s = i + n; e = s + lim;
          if (e > step) e = step;
          if (s < e) begin
            found = 1; from_prompt = 0; src = s; d = e - s;
          end
        end
      end
    end
    batch_total += d + 1;
    if (batch_total > TOTAL_MAX) batch_total = TOTAL_MAX;
    if (d == 0) push_draft(1, 1, 0, '0, 0, 1, keep);
    for (i = 0; i < d; i++) begin
      v = from_prompt ? prompt_mem[src + i] : hist_mem[src + i];
      push_draft(1, d + 1, i + 1, v, 1, i + 1 == d, keep);
    end
  endfunction

  function automatic void check_field(string name, logic [63:0] exp, logic [63:0] act);
    if (exp !== act) begin
      $error("%s: expected %0h, got %0h", name, exp, act);
      errs++;
    end
  endfunction

  always @(posedge clk) begin
    draft_t r;
    if (rst_n && out_tvalid && out_tready) begin
      n_drafts++;
      if (pending_drafts.size() == 0) begin
        $error("unexpected item: seq_len %0d draft_index %0d", out_tdata[4:0],
               out_tdata[9:5]);
        errs++;
      end else begin
        r = pending_drafts.pop_front();
        check_field("length_written", 64'(r.lw), 64'(out_tuser[0]));
        check_field("seq_len", 64'(r.seq), 64'(out_tdata[4:0]));
        check_field("draft_index", 64'(r.di), 64'(out_tdata[9:5]));
        check_field("draft_token", r.tok, out_tdata[73:10]);
        check_field("token_valid", 64'(r.tv), 64'(out_tuser[1]));
        check_field("last", 64'(r.last), 64'(out_tlast));
      end
    end
  end

  // result side: random stalls, one long hold-off to back the block up
  initial begin
    forever begin
      @(posedge clk);
      if (cyc == PRESS_AT) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      out_tready <= quiet() || $urandom_range(99) >= 27;
    end
  end

  task automatic send(cmd_t c, bit keep);
    while (!quiet() && $urandom_range(99) < 27) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= c.req;
    in_tdata <= {5'b0, c.lim, c.plen, c.step, c.idle, c.pf, c.anypf, c.bsize,
                 c.bidx, c.tok, c.pos};
    do @(posedge clk); while (!in_tready);
    lookup_drafts(c, keep);
    if (c.req == REQ_SEARCH) n_search++;
    else if (c.req != REQ_UNUSED) n_loads++;
  endtask

  task automatic apb_access(bit wr, logic idx, logic [31:0] wdata,
                            output logic [31:0] rdata);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= wr;
    cfg_paddr <= 3'(4 * idx); cfg_pwdata <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    rdata = cfg_prdata;
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_drafts.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_regs(int budget, int ngram);
    logic [31:0] rd;
    drain();
    apb_access(1, REG_TOKEN_BUDGET, 32'(budget), rd);
    apb_access(1, REG_MAX_NGRAM, 32'(ngram), rd);
    budget_reg = budget & 16'hFFFF;
    ngram_reg = ngram & 4'hF;
    apb_access(0, REG_TOKEN_BUDGET, '0, rd);
    check_field("token_budget", 64'(budget_reg), 64'(rd[15:0]));
    apb_access(0, REG_MAX_NGRAM, '0, rd);
    check_field("max_ngram", 64'(ngram_reg), 64'(rd[3:0]));
  endtask

  function automatic logic [63:0] rand_tok(bit wide);
    return wide ? {$urandom, $urandom} : 64'($urandom_range(3));
  endfunction

  int rnd_bidx = 0;

  function automatic cmd_t rand_cmd();
    cmd_t c;
    c = '0;
    c.req = ($urandom_range(99) < 30) ? (($urandom_range(1)) ? REQ_LOAD_PROMPT
                                                            : REQ_LOAD_HISTORY)
                                      : REQ_SEARCH;
    if ($urandom_range(49) == 0) c.req = REQ_UNUSED;
    if (c.req != REQ_SEARCH) begin
      if ($urandom_range(99) < 70) begin
        c.pos = 11'($urandom_range(FILL_LEN - 1));
        c.tok = rand_tok($urandom_range(9) == 0);
      end else begin
        c.pos = 11'($urandom);
        c.tok = rand_tok(1);
      end
      return c;
    end
    c.tok = rand_tok(1);
    c.pos = 11'($urandom);
    if ($urandom_range(99) < 15) begin
      {c.bidx, c.bsize, c.anypf, c.pf, c.idle} = 20'($urandom);
      c.step = 11'($urandom); c.plen = 12'($urandom); c.lim = 5'($urandom);
    end else begin
      c.bsize = 9'($urandom_range(1, 8));
      if (rnd_bidx >= c.bsize) rnd_bidx = 0;
      c.bidx = 8'(rnd_bidx);
      rnd_bidx++;
      c.anypf = $urandom_range(9) == 0;
      c.pf = c.anypf && $urandom_range(1);
      c.idle = $urandom_range(9) == 0;
      c.step = 11'($urandom_range(FILL_LEN - 1));
      c.plen = 12'($urandom_range(FILL_LEN));
      c.lim = 5'($urandom);
    end
    if (reads_stores(c)) begin
      c.step = 11'($urandom_range(FILL_LEN - 1));
      c.plen = 12'($urandom_range(FILL_LEN));
    end
    return c;
  endfunction

  dir_row_t dir_tab [12];

  initial begin
    cmd_t c;
    int base;
    budget_reg = BUDGET_RST;
    ngram_reg = NGRAM_RST;
    batch_total = 0;
    //            req               pos    tok      bidx bsize anypf pf idle step  plen  lim
    dir_tab = '{
      '{'{REQ_SEARCH,       11'd0, 64'd0,   8'd0, 9'd4, 1'b1, 1'b1, 1'b0, 11'd3, 12'd4, 5'd4},
        1, 5'd0, 1'b0, 1},
      '{'{REQ_SEARCH,       11'd0, 64'd0,   8'd1, 9'd4, 1'b1, 1'b0, 1'b1, 11'd3, 12'd4, 5'd4},
        1, 5'd0, 1'b1, 1},
      '{'{REQ_UNUSED,       '1,    '1,      '1,   '1,   1'b1, 1'b1, 1'b1, '1,    '1,    '1},
        1, 5'd0, 1'b0, 0},
      '{'{REQ_SEARCH,       11'd0, 64'd0,   8'd0, 9'd256, 1'b0, 1'b0, 1'b0, 11'd2047,
          12'd4095, 5'd31}, 1, 5'd1, 1'b1, 1},
      '{'{REQ_LOAD_PROMPT,  11'd2047, 64'h7FFF_FFFF_FFFF_FFFF, '0, '0, 0, 0, 0, '0, '0, '0},
        1, 5'd0, 1'b0, 0},
      '{'{REQ_LOAD_HISTORY, 11'd2047, 64'h8000_0000_0000_0000, '0, '0, 0, 0, 0, '0, '0, '0},
        1, 5'd0, 1'b0, 0},
      '{'{REQ_LOAD_PROMPT,  11'd4, 64'h8000_0000_0000_0000, '0, '0, 0, 0, 0, '0, '0, '0},
        1, 5'd0, 1'b0, 0},
      '{'{REQ_LOAD_HISTORY, 11'd31, 64'h8000_0000_0000_0000, '0, '0, 0, 0, 0, '0, '0, '0},
        1, 5'd0, 1'b0, 0},
      // limit saturates at MAX_DRAFT
      '{'{REQ_SEARCH,       11'd0, 64'd0,   8'd0, 9'd1, 1'b0, 1'b0, 1'b0, 11'd31, 12'd32, 5'd31},
        0, 5'd0, 1'b0, 0},
      '{'{REQ_SEARCH,       11'd0, 64'd0,   8'd1, 9'd2, 1'b1, 1'b0, 1'b0, 11'd31, 12'd32, 5'd0},
        1, 5'd1, 1'b1, 1},
      '{'{REQ_LOAD_PROMPT,  11'd5, '1,      '0, '0, 0, 0, 0, '0, '0, '0}, 1, 5'd0, 1'b0, 0},
      '{'{REQ_SEARCH,       11'd0, 64'd0,   8'd255, 9'd511, 1'b0, 1'b0, 1'b0, 11'd31,
          12'd32, 5'd16}, 0, 5'd0, 1'b0, 0}
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // make the searched windows readable
    for (int k = 0; k < 2 * FILL_LEN; k++) begin
      c = '0;
      c.req = (k < FILL_LEN) ? REQ_LOAD_PROMPT : REQ_LOAD_HISTORY;
      c.pos = 11'(k % FILL_LEN);
      c.tok = rand_tok(0);
      send(c, 1);
    end

    foreach (dir_tab[k]) begin
      send(dir_tab[k].c, !dir_tab[k].typed);
      if (dir_tab[k].typed && dir_tab[k].n_exp != 0)
        push_draft(dir_tab[k].e_lw, dir_tab[k].e_seq, 0, '0, 0, 1, 1);
    end

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1: set_regs(65535, 8);
        2: set_regs(0, 1);
        3: set_regs(20, 0);
        4: set_regs(300, 15);
        default: ;
      endcase
      base = n_search + n_loads;
      while (n_search + n_loads - base < 13) send(rand_cmd(), 1);
    end
    drain();

    $display("covered %0d loads and %0d searches, %0d result items checked",
             n_loads, n_search, n_drafts);
    $display("register settings: budget 128/65535/0/20/300, max n-gram 3/8/1/0/15");
    if (errs == 0)
      $display("ngram_draft_token_lookup_unit test passed");
    else
      $display("ngram_draft_token_lookup_unit test failed");
    $finish;
  end

  initial begin
    #100ms;
    $display("ngram_draft_token_lookup_unit test failed");
    $finish;
  end

endmodule
